/* rtl/core/csds_pkg.sv */
// Shared types, constants and a helper function for the clock setting and digit scan block.
package csds_pkg;

	// time arithmetic
	localparam logic [17:0] DAY_HALF_SECONDS = 18'd172800;
	localparam logic [16:0] HOUR_SECONDS     = 17'd3600;
	localparam logic [11:0] MINUTE_SECONDS   = 12'd60;
	localparam logic [5:0]  HOURS_PER_DAY    = 6'd24;
	localparam logic [5:0]  LAST_MINUTE      = 6'd59;
	localparam logic [5:0]  TEN              = 6'd10;

	// floor(x/3600) for x < 2^17 and floor(x/60) for x < 3600, by reciprocal multiply
	localparam logic [17:0] HOUR_RECIP       = 18'd149131;
	localparam int          HOUR_RECIP_SHIFT = 29;
	localparam logic [12:0] MIN_RECIP        = 13'd4370;
	localparam int          MIN_RECIP_SHIFT  = 18;

	// display codes
	localparam logic [4:0] BLANK_CODE = 5'd20;
	localparam logic [4:0] DOT_OFFSET = 5'd10;

	// digit positions
	localparam int          STORE_DIGITS   = 6;
	localparam int          DIGITS_DEFAULT = 6;
	localparam logic [2:0]  IDX_HOUR_TENS  = 3'd0;
	localparam logic [2:0]  IDX_MIN_ONES   = 3'd3;

	// configuration port
	localparam int   ADDR_W           = 3;
	localparam int   DATA_W           = 32;
	localparam logic REG_SHOW_SECONDS = 1'b0;

	typedef logic [4:0] code_t;
	typedef code_t [STORE_DIGITS-1:0] code_row_t;

	typedef struct packed {
		logic hour;
		logic minute;
		logic second;
	} buttons_t;

	typedef struct packed {
		logic [5:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [17:0] count;
		buttons_t    buttons;
	} clock_fields_t;

	typedef struct packed {
		logic        changed;
		logic [17:0] count;
		code_row_t   codes;
	} frame_t;

	typedef struct packed {
		logic [2:0] tens;
		logic [3:0] ones;
	} bcd_t;

	// split a value below 64 into tens and ones
	function automatic bcd_t split_tens(input logic [5:0] v);
		bcd_t       r;
		logic [2:0] q;
		logic [5:0] prod;
		q = 3'd0;
		if (v >= 6'd10) q = 3'd1;
		if (v >= 6'd20) q = 3'd2;
		if (v >= 6'd30) q = 3'd3;
		if (v >= 6'd40) q = 3'd4;
		if (v >= 6'd50) q = 3'd5;
		if (v >= 6'd60) q = 3'd6;
		prod   = 6'({3'b000, q} * TEN);
		r.tens = q;
		r.ones = 4'(v - prod);
		return r;
	endfunction

endpackage

/* rtl/core/csds_split.sv */
// Four-stage split of the half-second count into hour, minute and second.
module csds_split (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [17:0]             in_count,
	input  csds_pkg::buttons_t      in_buttons,
	output logic                    out_valid,
	input  logic                    out_ready,
	output csds_pkg::clock_fields_t out_fields
);
	import csds_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [17:0] count_s1, count_s2, count_s3, count_s4;
	buttons_t    btn_s1, btn_s2, btn_s3, btn_s4;
	logic [16:0] half_s2;
	logic [5:0]  hour_s2, hour_s3, hour_s4;
	logic [11:0] rem_s3, rem_s4;
	logic [5:0]  min_s4;

	logic [16:0] half;
	logic [34:0] hour_prod;
	logic [5:0]  hour_est;
	logic [16:0] hour_diff;
	logic [24:0] min_prod;
	logic [5:0]  min_est;
	logic [11:0] sec_diff;

	assign rdy_s4   = !valid_s4 || out_ready;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	// hour = floor(half / 3600)
	assign half      = count_s1[17:1];
	assign hour_prod = 35'(half) * 35'(HOUR_RECIP);
	assign hour_est  = hour_prod[HOUR_RECIP_SHIFT +: 6];

	// remainder within the hour
	assign hour_diff = half_s2 - 17'(17'(hour_s2) * HOUR_SECONDS);

	// minute = floor(rem / 60)
	assign min_prod = 25'(rem_s3) * 25'(MIN_RECIP);
	assign min_est  = min_prod[MIN_RECIP_SHIFT +: 6];

	assign sec_diff = rem_s4 - 12'(12'(min_s4) * MINUTE_SECONDS);

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			count_s1 <= in_count;
			btn_s1   <= in_buttons;
		end
		if (valid_s1 && rdy_s2) begin
			count_s2 <= count_s1;
			btn_s2   <= btn_s1;
			half_s2  <= half;
			hour_s2  <= hour_est;
		end
		if (valid_s2 && rdy_s3) begin
			count_s3 <= count_s2;
			btn_s3   <= btn_s2;
			hour_s3  <= hour_s2;
			rem_s3   <= hour_diff[11:0];
		end
		if (valid_s3 && rdy_s4) begin
			count_s4 <= count_s3;
			btn_s4   <= btn_s3;
			hour_s4  <= hour_s3;
			rem_s4   <= rem_s3;
			min_s4   <= min_est;
		end
	end

	assign out_valid          = valid_s4;
	assign out_fields.hour    = hour_s4;
	assign out_fields.minute  = min_s4;
	assign out_fields.second  = sec_diff[5:0];
	assign out_fields.count   = count_s4;
	assign out_fields.buttons = btn_s4;

endmodule

/* rtl/core/csds_rebuild.sv */
// Button handling, count rebuild and digit code generation, two stages.
module csds_rebuild (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  csds_pkg::clock_fields_t in_fields,
	output logic                    out_valid,
	input  logic                    out_ready,
	output csds_pkg::frame_t        out_frame
);
	import csds_pkg::*;

	logic valid_s5, valid_s6;
	logic rdy_s5, rdy_s6;

	logic [5:0]  hour_s5, minute_s5, second_s5;
	logic        changed_s5;
	logic [17:0] count_s5;
	frame_t      frame_s6;

	logic [5:0]  hour_inc, hour_adj, minute_adj, second_adj;
	logic [17:0] total;
	logic [18:0] doubled;
	logic [18:0] wrapped;
	logic [17:0] count_final;
	bcd_t        hour_bcd, minute_bcd, second_bcd;
	code_row_t   codes;

	assign rdy_s6   = !valid_s6 || out_ready;
	assign rdy_s5   = !valid_s5 || rdy_s6;
	assign in_ready = rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy_s5) valid_s5 <= in_valid;
			if (rdy_s6) valid_s6 <= valid_s5;
		end
	end

	// hour may be out of range (up to 36) when the count is; (h+1) mod 24 still
	// needs only one subtract
	always_comb begin
		hour_inc = in_fields.hour + 6'd1;
		if (hour_inc >= HOURS_PER_DAY) hour_inc = hour_inc - HOURS_PER_DAY;
		hour_adj   = in_fields.buttons.hour ? hour_inc : in_fields.hour;
		minute_adj = in_fields.minute;
		if (in_fields.buttons.minute) begin
			minute_adj = (in_fields.minute == LAST_MINUTE) ? 6'd0 : in_fields.minute + 6'd1;
		end
		second_adj = in_fields.buttons.second ? 6'd0 : in_fields.second;
	end

	// an out of range hour kept as is can push the total past 2^17
	always_comb begin
		total   = 18'(18'(hour_s5) * 18'(HOUR_SECONDS))
		        + 18'(18'(minute_s5) * 18'(MINUTE_SECONDS)) + 18'(second_s5);
		doubled = {total, 1'b0};
		wrapped = doubled;
		if (doubled >= 19'(DAY_HALF_SECONDS)) wrapped = doubled - 19'(DAY_HALF_SECONDS);
		count_final = changed_s5 ? wrapped[17:0] : count_s5;
	end

	assign hour_bcd   = split_tens(hour_s5);
	assign minute_bcd = split_tens(minute_s5);
	assign second_bcd = split_tens(second_s5);

	always_comb begin
		codes[0] = (hour_bcd.tens == 3'd0) ? BLANK_CODE : 5'(hour_bcd.tens);
		codes[1] = 5'(hour_bcd.ones);
		codes[2] = 5'(minute_bcd.tens);
		codes[3] = 5'(minute_bcd.ones);
		codes[4] = 5'(second_bcd.tens);
		codes[5] = 5'(second_bcd.ones);
		// dot on even counts
		if (!count_final[0]) begin
			codes[1] = codes[1] + DOT_OFFSET;
			codes[3] = codes[3] + DOT_OFFSET;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s5) begin
			hour_s5    <= hour_adj;
			minute_s5  <= minute_adj;
			second_s5  <= second_adj;
			changed_s5 <= in_fields.buttons.hour || in_fields.buttons.minute
			              || in_fields.buttons.second;
			count_s5   <= in_fields.count;
		end
		if (valid_s5 && rdy_s6) begin
			frame_s6.changed <= changed_s5;
			frame_s6.count   <= count_final;
			frame_s6.codes   <= codes;
		end
	end

	assign out_valid = valid_s6;
	assign out_frame = frame_s6;

endmodule

/* rtl/core/csds_scan.sv */
// Stored digit codes, scan pointer and the result register.
module csds_scan #(
	parameter int DIGITS = csds_pkg::DIGITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             show_seconds,
	input  logic             in_valid,
	output logic             in_ready,
	input  csds_pkg::frame_t in_frame,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             count_write,
	output logic [17:0]      new_count,
	output logic [2:0]       digit_index,
	output logic [4:0]       digit_code
);
	import csds_pkg::*;

	localparam int IDX_W = $clog2(DIGITS);

	logic [2:0]  ptr_q;
	logic [17:0] last_q;
	code_t       codes_q [DIGITS];

	logic        out_valid_q;
	logic        count_write_q;
	logic [17:0] new_count_q;
	logic [2:0]  digit_index_q;
	code_t       digit_code_q;

	logic       take;
	logic       refresh;
	logic [2:0] ptr_inc;
	logic [2:0] ptr_next;
	code_t      code_sel;

	assign in_ready = !out_valid_q || !out_stall;
	assign take     = in_valid && in_ready;
	assign refresh  = (ptr_q == IDX_HOUR_TENS) && (in_frame.count != last_q);
	assign code_sel = refresh ? in_frame.codes[0] : codes_q[ptr_q[IDX_W-1:0]];

	always_comb begin
		ptr_inc  = ptr_q + 3'd1;
		ptr_next = ptr_inc;
		if ((!show_seconds && ptr_inc > IDX_MIN_ONES) || ptr_inc >= 3'(DIGITS)) ptr_next = 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= 3'd0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIGITS; i++) codes_q[i] <= '0;
		end else begin
			if (in_ready) out_valid_q <= in_valid;
			if (take) begin
				ptr_q <= ptr_next;
				if (refresh) begin
					last_q <= in_frame.count;
					for (int i = 0; i < DIGITS; i++) codes_q[i] <= in_frame.codes[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			count_write_q <= in_frame.changed;
			new_count_q   <= in_frame.count;
			digit_index_q <= ptr_q;
			digit_code_q  <= code_sel;
		end
	end

	assign out_valid   = out_valid_q;
	assign count_write = count_write_q;
	assign new_count   = new_count_q;
	assign digit_index = digit_index_q;
	assign digit_code  = digit_code_q;

endmodule

/* rtl/core/clock_setting_and_digit_scan.sv */
// Top level: time setting and multiplexed digit scan for a clock display.
//
// One frame is transferred on the time channel (time_valid / time_stall) with the
// half-second count and the three button levels. Each frame yields one result on
// the display channel (disp_valid / disp_stall): the write-back flag and count,
// and the digit index and code to drive this frame.
// Throughput: one frame per cycle while disp_stall is low; the path is a
// seven-register pipeline (four split stages, two rebuild stages, the result
// register). A stalled result holds; stages behind it keep filling, and
// time_stall rises only once every stage holds a frame.
// Reset clears the scan pointer, the last shown count, the stored digit codes
// and all pipeline valids; show_seconds resets to 1.
// Register 0 (byte address 0) is show_seconds: 1 scans all digits, 0 only the
// hour and minute digits. Write it only while the pipeline is empty.
module clock_setting_and_digit_scan #(
	parameter int DIGITS = csds_pkg::DIGITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csds_pkg::ADDR_W-1:0] paddr,
	input  logic [csds_pkg::DATA_W-1:0] pwdata,
	output logic [csds_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        time_valid,
	output logic                        time_stall,
	input  logic [17:0]                 time_count,
	input  logic                        hour_button,
	input  logic                        minute_button,
	input  logic                        second_reset_button,
	output logic                        disp_valid,
	input  logic                        disp_stall,
	output logic                        count_write,
	output logic [17:0]                 new_count,
	output logic [2:0]                  digit_index,
	output logic [4:0]                  digit_code
);
	import csds_pkg::*;

	logic show_q;
	logic reg_index;

	buttons_t      buttons;
	logic          split_ready;
	logic          split_valid;
	clock_fields_t split_fields;
	logic          rebuild_ready;
	logic          rebuild_valid;
	frame_t        rebuild_frame;
	logic          scan_ready;

	assign reg_index = paddr[ADDR_W-1];
	assign pready    = 1'b1;
	assign prdata    = (reg_index == REG_SHOW_SECONDS) ? {{(DATA_W-1){1'b0}}, show_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && reg_index == REG_SHOW_SECONDS) begin
			show_q <= pwdata[0];
		end
	end

	assign buttons.hour   = hour_button;
	assign buttons.minute = minute_button;
	assign buttons.second = second_reset_button;
	assign time_stall     = !split_ready;

	csds_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (time_valid),
		.in_ready   (split_ready),
		.in_count   (time_count),
		.in_buttons (buttons),
		.out_valid  (split_valid),
		.out_ready  (rebuild_ready),
		.out_fields (split_fields)
	);

	csds_rebuild u_rebuild (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_ready  (rebuild_ready),
		.in_fields (split_fields),
		.out_valid (rebuild_valid),
		.out_ready (scan_ready),
		.out_frame (rebuild_frame)
	);

	csds_scan #(
		.DIGITS (DIGITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.show_seconds (show_q),
		.in_valid     (rebuild_valid),
		.in_ready     (scan_ready),
		.in_frame     (rebuild_frame),
		.out_valid    (disp_valid),
		.out_stall    (disp_stall),
		.count_write  (count_write),
		.new_count    (new_count),
		.digit_index  (digit_index),
		.digit_code   (digit_code)
	);

endmodule

/* dv/clock_setting_and_digit_scan_test.sv */
`timescale 1ns / 100ps
// Testbench for clock_setting_and_digit_scan: random frames checked against a display scoreboard.
module clock_setting_and_digit_scan_test;

	localparam int unsigned DAY_HALVES = 172800;
	localparam int unsigned HOUR_SECS = 3600;
	localparam int unsigned MIN_SECS = 60;
	localparam int unsigned HOURS = 24;
	localparam int unsigned MINUTES = 60;
	localparam int unsigned RADIX = 10;
	localparam int ADDR_BITS = csds_pkg::ADDR_W;
	localparam int REG_SPARE = 1;
	localparam int LIMIT_CYCLES = 600000;
	localparam int PHASES = 6;
	localparam int FRAMES_PER_PHASE = 240;
	localparam int HOLD_AFTER = 800;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 20;
	localparam int N_DIRECTED = 20;

	typedef struct packed {
		bit [17:0] cnt;
		bit        hour_b;
		bit        min_b;
		bit        sec_b;
	} frame_in_t;

	typedef struct {
		logic        count_write;
		logic [17:0] new_count;
		logic [2:0]  digit_index;
		logic [4:0]  digit_code;
	} display_result_t;

	class display_scoreboard;
		bit              show_seconds = 1'b1;
		bit [4:0]        digit_store[csds_pkg::STORE_DIGITS];
		int unsigned     scan_ptr = 0;
		bit [17:0]       last_shown = '0;
		display_result_t pending_results[$];
		int              errors = 0;
		int              results_seen = 0;

		function void report(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
			end
		endfunction

		function void write_reg(int idx, logic [31:0] value);
			if (idx == int'(csds_pkg::REG_SHOW_SECONDS)) begin
				show_seconds = value[0];
			end
		endfunction

		// one accepted frame: apply buttons, refresh digits at scan start, advance scan
		function void note_frame(frame_in_t f);
			int unsigned     half, hr, mn, sc;
			bit              changed;
			bit [17:0]       shown;
			display_result_t r;
			half = f.cnt / 2;
			hr = half / HOUR_SECS;
			mn = (half % HOUR_SECS) / MIN_SECS;
			sc = half % MIN_SECS;
			changed = f.hour_b | f.min_b | f.sec_b;
			if (f.hour_b) hr = (hr + 1) % HOURS;
			if (f.min_b) mn = (mn + 1) % MINUTES;
			if (f.sec_b) sc = 0;
			shown = changed ? 18'(((hr * HOUR_SECS + mn * MIN_SECS + sc) * 2) % DAY_HALVES)
				: f.cnt;
			if (scan_ptr == 0 && shown != last_shown) begin
				last_shown = shown;
				digit_store[0] = (hr / RADIX == 0) ? csds_pkg::BLANK_CODE : 5'(hr / RADIX);
				digit_store[1] = 5'(hr % RADIX);
				digit_store[2] = 5'(mn / RADIX);
				digit_store[3] = 5'(mn % RADIX);
				digit_store[4] = 5'(sc / RADIX);
				digit_store[5] = 5'(sc % RADIX);
				if (!shown[0]) begin
					digit_store[1] += csds_pkg::DOT_OFFSET;
					digit_store[3] += csds_pkg::DOT_OFFSET;
				end
			end
			r.count_write = changed;
			r.new_count = shown;
			r.digit_index = 3'(scan_ptr);
			r.digit_code = digit_store[scan_ptr];
			pending_results.push_back(r);
			scan_ptr++;
			if (!show_seconds && scan_ptr > csds_pkg::IDX_MIN_ONES) scan_ptr = 0;
			if (scan_ptr >= csds_pkg::DIGITS_DEFAULT) scan_ptr = 0;
		endfunction

		function void check_frame(logic cw, logic [17:0] nc, logic [2:0] idx, logic [4:0] code);
			display_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: result with no frame pending (index %0d, code %0d)",
						$time, idx, code);
				end
				return;
			end
			want = pending_results.pop_front();
			if (cw !== want.count_write) report("count_write", want.count_write, cw);
			if (nc !== want.new_count) report("new_count", want.new_count, nc);
			if (idx !== want.digit_index) report("digit_index", want.digit_index, idx);
			if (code !== want.digit_code) report("digit_code", want.digit_code, code);
		endfunction

		function void finish_check();
			if (pending_results.size() != 0) begin
				errors += pending_results.size();
				$display("%0d frames never produced a result", pending_results.size());
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [csds_pkg::DATA_W-1:0] pwdata, prdata;
	logic pready;
	logic time_valid, time_stall;
	logic [17:0] time_count;
	logic hour_button, minute_button, second_reset_button;
	logic disp_valid, disp_stall;
	logic count_write;
	logic [17:0] new_count;
	logic [2:0] digit_index;
	logic [4:0] digit_code;

	display_scoreboard sb;
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit held_once = 1'b0;
	int cycles = 0;

	const frame_in_t DIRECTED[N_DIRECTED] = '{
		'{18'd0, 1'b0, 1'b0, 1'b0},       // zero count equals the reset count: no refresh
		'{18'd172799, 1'b0, 1'b0, 1'b0},  // last valid count, odd
		'{18'd172798, 1'b1, 1'b0, 1'b0},  // hour wraps 23 -> 0
		'{18'd172800, 1'b0, 1'b0, 1'b0},  // out of range, hour 24
		'{18'd262143, 1'b0, 1'b0, 1'b0},  // field max, hour 36
		'{18'd262142, 1'b1, 1'b0, 1'b0},  // out of range hour advanced mod 24
		'{18'd262143, 1'b0, 1'b1, 1'b0},
		'{18'd7199, 1'b0, 1'b1, 1'b0},    // minute wraps 59 -> 0
		'{18'd119, 1'b0, 1'b0, 1'b1},
		'{18'd172799, 1'b1, 1'b1, 1'b1},  // all buttons: rebuild to zero
		'{18'd1, 1'b0, 1'b0, 1'b0},
		'{18'd2, 1'b0, 1'b0, 1'b0},
		'{18'd72000, 1'b0, 1'b0, 1'b0},
		'{18'd72000, 1'b0, 1'b0, 1'b0},   // same count again
		'{18'd144001, 1'b0, 1'b0, 1'b0},
		'{18'd36000, 1'b0, 1'b1, 1'b1},
		'{18'd3, 1'b0, 1'b0, 1'b0},
		'{18'd100000, 1'b1, 1'b1, 1'b0},
		'{18'd50000, 1'b0, 1'b0, 1'b0},
		'{18'd165600, 1'b0, 1'b0, 1'b1}
	};

	clock_setting_and_digit_scan dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.time_valid(time_valid), .time_stall(time_stall), .time_count(time_count),
		.hour_button(hour_button), .minute_button(minute_button),
		.second_reset_button(second_reset_button),
		.disp_valid(disp_valid), .disp_stall(disp_stall),
		.count_write(count_write), .new_count(new_count),
		.digit_index(digit_index), .digit_code(digit_code)
	);

	always #6 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// display side: check each transfer, then pick the next stall level
	always @(posedge clk) begin
		if (arst_n && disp_valid && !disp_stall) begin
			sb.check_frame(count_write, new_count, digit_index, digit_code);
		end
		if (hold_left > 0) begin
			hold_left--;
			disp_stall <= 1'b1;
		end else if (!held_once && sb.results_seen >= HOLD_AFTER) begin
			// long hold so the pipeline fills and the input side stalls
			held_once = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			disp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			disp_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = pick_gap() - 1;
			disp_stall <= 1'b1;
		end else begin
			disp_stall <= 1'b0;
		end
	end

	// write a register, then read show_seconds back
	task automatic write_and_verify(int idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
		psel <= 1'b1;
		paddr <= ADDR_BITS'(4 * int'(csds_pkg::REG_SHOW_SECONDS));
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== 32'(sb.show_seconds)) begin
			sb.report("show_seconds readback", 32'(sb.show_seconds), prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drive_frame(frame_in_t f, bit last);
		time_valid <= 1'b1;
		time_count <= f.cnt;
		hour_button <= f.hour_b;
		minute_button <= f.min_b;
		second_reset_button <= f.sec_b;
		@(posedge clk);
		while (time_stall) @(posedge clk);
		sb.note_frame(f);
		if (last || $urandom_range(0, 99) < gap_pct) begin
			time_valid <= 1'b0;
			if (!last) repeat (pick_gap()) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		frame_in_t f;
		bit [17:0] prev;
		int p, i;
		sb = new;
		prev = '0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		time_valid <= 1'b0;
		time_count <= '0;
		hour_button <= 1'b0;
		minute_button <= 1'b0;
		second_reset_button <= 1'b0;
		disp_stall <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_and_verify(int'(csds_pkg::REG_SHOW_SECONDS), 32'd1);
		for (i = 0; i < N_DIRECTED; i++) drive_frame(DIRECTED[i], i == N_DIRECTED - 1);
		wait_drained();
		// a write outside the register map must leave show_seconds alone
		write_and_verify(REG_SPARE, 32'd0);

		for (p = 0; p < PHASES; p++) begin
			write_and_verify(int'(csds_pkg::REG_SHOW_SECONDS), (p % 2 == 0) ? 32'd0 : 32'd1);
			case (p % 3)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 10;
					stall_pct = 20;
				end
				default: begin
					gap_pct = 40;
					stall_pct = 40;
				end
			endcase
			for (i = 0; i < FRAMES_PER_PHASE; i++) begin
				case ($urandom_range(0, 19)) inside
					[0:8]: begin
						// ticking clock: often the same count, so no refresh
						f.cnt = 18'((prev + $urandom_range(0, 3)) % DAY_HALVES);
					end
					[9:14]: f.cnt = 18'($urandom_range(0, 262143));
					[15:17]: f.cnt = 18'($urandom_range(0, DAY_HALVES - 1));
					default: begin
						case ($urandom_range(0, 5))
							0: f.cnt = 18'd0;
							1: f.cnt = 18'd1;
							2: f.cnt = 18'd172798;
							3: f.cnt = 18'd172799;
							4: f.cnt = 18'd172800;
							default: f.cnt = 18'd262143;
						endcase
					end
				endcase
				f.hour_b = ($urandom_range(0, 3) == 0);
				f.min_b = ($urandom_range(0, 3) == 0);
				f.sec_b = ($urandom_range(0, 3) == 0);
				prev = f.cnt;
				drive_frame(f, i == FRAMES_PER_PHASE - 1);
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.finish_check();
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* clock_setting_and_digit_scan.f */
rtl/core/csds_pkg.sv
rtl/core/csds_split.sv
rtl/core/csds_rebuild.sv
rtl/core/csds_scan.sv
rtl/core/clock_setting_and_digit_scan.sv
dv/clock_setting_and_digit_scan_test.sv
